FILE: hdl/str_pkg.sv
// shared types, widths and codes for the stepper trapezoid ramp unit
`timescale 1ns / 1ps
`default_nettype none

package str_pkg;

  // width of the step position, target and brake point counters
  localparam int unsigned STEP_BITS    = 32;
  // fixed widths of the channel fields, the fraction and the settings
  localparam int unsigned STEP_COUNT_W = 32;
  localparam int unsigned SPEED_W      = 17;
  localparam int unsigned FRAC_W       = 16;
  localparam int unsigned SPEED_MAX_W  = 16;
  localparam int unsigned ACCEL_W      = 8;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;

  // ramp phase
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ACCEL = 2'd1,
    PH_RUN   = 2'd2,
    PH_DECEL = 2'd3
  } phase_e;

  // request codes (code three means nothing and is ignored)
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP = 2'd1;

  // one result beat
  typedef struct packed {
    logic                    accepted;
    logic                    step_pulse;
    phase_e                  phase;
    logic [SPEED_W-1:0]      speed_now;
    logic [STEP_COUNT_W-1:0] steps_done;
  } resp_t;

endpackage

`default_nettype wire

FILE: hdl/str_if.sv
// valid/ready channel interfaces for requests, results and configuration writes
`timescale 1ns / 1ps
`default_nettype none

// request channel
interface str_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       req_type;
  logic [str_pkg::STEP_COUNT_W-1:0] step_count;

  modport source (output valid, output req_type, output step_count, input ready);
  modport sink   (input valid, input req_type, input step_count, output ready);
endinterface

// result channel
interface str_resp_if;
  logic                             valid;
  logic                             ready;
  logic                             accepted;
  logic                             step_pulse;
  str_pkg::phase_e                  phase;
  logic [str_pkg::SPEED_W-1:0]      speed_now;
  logic [str_pkg::STEP_COUNT_W-1:0] steps_done;

  modport source (output valid, output accepted, output step_pulse, output phase,
                  output speed_now, output steps_done, input ready);
  modport sink   (input valid, input accepted, input step_pulse, input phase,
                  input speed_now, input steps_done, output ready);
endinterface

// configuration write channel
interface str_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [str_pkg::CFG_IDX_W-1:0]  index;
  logic [str_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/stepper_trapezoid_ramp_unit.sv
// trapezoidal stepper ramp generator with 16.16 phase accumulator, top level
//
//   channel  | dir | payload                                          | beat when
//   ---------+-----+--------------------------------------------------+------------------
//   cfg_i    | in  | index, data                                      | valid && ready
//   req_i    | in  | req_type, step_count                             | valid && ready
//   resp_o   | out | accepted, step_pulse, phase, speed_now, steps_done | valid && ready
//
// one request per cycle while ready; its result is registered in the output stage
// the ramp state is updated in the accepting cycle by the add/compare path alone
// a two-deep output stage (result register plus skid register) keeps req_i ready
// while one result waits; req_i.ready drops only when both hold a result
// cfg_i is always ready; reset clears the ramp state, the settings and both valid flags
`timescale 1ns / 1ps
`default_nettype none

module stepper_trapezoid_ramp_unit (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  str_cfg_if.sink     cfg_i,
  str_req_if.sink     req_i,
  str_resp_if.source  resp_o
);
  import str_pkg::*;

  // configuration registers
  logic [SPEED_MAX_W-1:0]  speed_max_q;
  logic [ACCEL_W-1:0]      accel_step_q;

  // ramp state
  phase_e                  phase_q, phase_d;
  logic [SPEED_W-1:0]      speed_q, speed_d;
  logic [FRAC_W-1:0]       frac_q, frac_d;
  logic [STEP_BITS-1:0]    done_q, done_d;
  logic [STEP_BITS-1:0]    target_q, target_d;
  logic [STEP_BITS-2:0]    half_q, half_d;
  logic [STEP_BITS-1:0]    brake_q, brake_d;
  logic                    flag_q, flag_d;

  // output stage
  logic                    out_valid_q, skid_valid_q;
  resp_t                   out_q, skid_q;
  resp_t                   res;
  logic                    acc;
  logic                    in_beat, out_pop;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = ~skid_valid_q;
  assign in_beat     = req_i.valid & req_i.ready;
  assign out_pop     = out_valid_q & resp_o.ready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_max_q  <= '0;
      accel_step_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_SPEED_MAX:  speed_max_q  <= cfg_i.data[SPEED_MAX_W-1:0];
        REG_ACCEL_STEP: accel_step_q <= cfg_i.data[ACCEL_W-1:0];
        default: ;
      endcase
    end
  end

  // request decode, phase action and fraction accumulate
  always_comb begin
    logic [SPEED_W-1:0]  accel_ext;
    logic [SPEED_W-1:0]  spd_up;
    logic [SPEED_W-1:0]  spd_dn;
    logic [SPEED_W-1:0]  spd_act;
    logic [SPEED_W:0]    sum;
    logic                carry;

    accel_ext = SPEED_W'(accel_step_q);
    spd_up    = speed_q + accel_ext;
    spd_dn    = (speed_q < accel_ext) ? '0 : speed_q - accel_ext;
    spd_act   = speed_q;
    sum       = '0;
    carry     = 1'b0;

    phase_d  = phase_q;
    speed_d  = speed_q;
    frac_d   = frac_q;
    done_d   = done_q;
    target_d = target_q;
    half_d   = half_q;
    brake_d  = brake_q;
    flag_d   = flag_q;
    acc      = 1'b0;

    unique case (req_i.req_type)
      REQ_TICK: begin
        if (phase_q != PH_IDLE) begin
          acc = 1'b1;
          // one phase action
          unique case (phase_q)
            PH_ACCEL: begin
              spd_act = spd_up;
              if (done_q == {1'b0, half_q}) begin
                phase_d = PH_DECEL;
              end else if (spd_up >= SPEED_W'(speed_max_q)) begin
                phase_d = PH_RUN;
                spd_act = SPEED_W'(speed_max_q);
                brake_d = target_q - done_q;
              end
            end
            PH_RUN: begin
              if (done_q == brake_q) begin
                phase_d = PH_DECEL;
              end
            end
            default: begin
              spd_act = spd_dn;
              if (spd_dn == '0) begin
                phase_d = PH_IDLE;
              end
            end
          endcase
          // add speed to the fraction, carry out of 16 bits is a step
          sum     = {1'b0, spd_act} + (SPEED_W + 1)'(frac_q);
          carry   = |sum[SPEED_W:FRAC_W];
          speed_d = spd_act;
          frac_d  = sum[FRAC_W-1:0];
          done_d  = done_q + STEP_BITS'(carry);
          flag_d  = carry;
        end
      end
      REQ_START: begin
        if (phase_q == PH_IDLE) begin
          acc      = 1'b1;
          phase_d  = PH_ACCEL;
          speed_d  = '0;
          frac_d   = '0;
          done_d   = '0;
          brake_d  = '0;
          flag_d   = 1'b0;
          target_d = STEP_BITS'(req_i.step_count);
          half_d   = target_d[STEP_BITS-1:1];
        end
      end
      REQ_STOP: begin
        if (phase_q != PH_IDLE) begin
          acc     = 1'b1;
          phase_d = PH_DECEL;
        end
      end
      default: ;
    endcase

    res.accepted   = acc;
    res.step_pulse = flag_d;
    res.phase      = phase_d;
    res.speed_now  = speed_d;
    res.steps_done = STEP_COUNT_W'(done_d);
  end

  // ramp state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      speed_q  <= '0;
      frac_q   <= '0;
      done_q   <= '0;
      target_q <= '0;
      half_q   <= '0;
      brake_q  <= '0;
      flag_q   <= 1'b0;
    end else if (in_beat) begin
      phase_q  <= phase_d;
      speed_q  <= speed_d;
      frac_q   <= frac_d;
      done_q   <= done_d;
      target_q <= target_d;
      half_q   <= half_d;
      brake_q  <= brake_d;
      flag_q   <= flag_d;
    end
  end

  // output stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_pop) begin
      out_valid_q  <= skid_valid_q | in_beat;
      skid_valid_q <= 1'b0;
    end else if (in_beat) begin
      skid_valid_q <= 1'b1;
    end
  end

  // output stage payload
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_pop) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_beat) begin
      skid_q <= res;
    end
  end

  assign resp_o.valid      = out_valid_q;
  assign resp_o.accepted   = out_q.accepted;
  assign resp_o.step_pulse = out_q.step_pulse;
  assign resp_o.phase      = out_q.phase;
  assign resp_o.speed_now  = out_q.speed_now;
  assign resp_o.steps_done = out_q.steps_done;

endmodule

`default_nettype wire

FILE: hdl/str_checker.sv
// port-level checks for the stepper trapezoid ramp unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module str_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             req_ready,
  input wire logic                             resp_valid,
  input wire logic                             resp_ready,
  input wire logic                             resp_accepted,
  input wire logic                             resp_step_pulse,
  input wire str_pkg::phase_e                  resp_phase,
  input wire logic [str_pkg::SPEED_W-1:0]      resp_speed_now,
  input wire logic [str_pkg::STEP_COUNT_W-1:0] resp_steps_done
);
  import str_pkg::*;

  // a stalled result beat holds
  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid && !resp_ready |=> resp_valid && $stable(resp_accepted)
      && $stable(resp_step_pulse) && $stable(resp_phase)
      && $stable(resp_speed_now) && $stable(resp_steps_done))
    else $error("result beat changed while stalled");

  // requests back up only behind a held result
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready |-> resp_valid)
    else $error("request channel stalled with no result waiting");

  // an idle ramp stands still
  a_idle_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid && resp_phase == PH_IDLE |-> resp_speed_now == '0)
    else $error("idle phase with nonzero speed");

  // no step is reported from idle
  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid && resp_step_pulse |-> resp_phase != PH_IDLE)
    else $error("step pulse reported in idle phase");

endmodule

bind stepper_trapezoid_ramp_unit str_checker u_str_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_ready       (req_i.ready),
  .resp_valid      (resp_o.valid),
  .resp_ready      (resp_o.ready),
  .resp_accepted   (resp_o.accepted),
  .resp_step_pulse (resp_o.step_pulse),
  .resp_phase      (resp_o.phase),
  .resp_speed_now  (resp_o.speed_now),
  .resp_steps_done (resp_o.steps_done)
);

`default_nettype wire
